// ===== src/gbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Window sizing, field types, result and command codes and FSM states.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int WINDOW    = 8;
    localparam int SEQ_BITS  = 32;
    localparam int TIME_BITS = 32;
    localparam int TO_BITS   = 16;
    localparam int SLOT_BITS = $clog2(WINDOW);
    localparam int CNT_BITS  = $clog2(WINDOW + 1);

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_RETX = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;
    localparam logic [1:0] KIND_ACK  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic        ack_valid;
        logic [7:0]  ack_flags;
        logic [31:0] ack_seq;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           kind;
        logic [31:0]          seq_no;
        logic [SLOT_BITS-1:0] slot;
        logic [31:0]          base_seq;
        logic                 last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RESEND
    } t_state;

endpackage

// ===== src/go_back_n_sender_window_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-Back-N sender window core
// Sequence assignment, cumulative ack tracking and timeout resend, with the
// per-slot send stamps held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   | ports                       | handshake
//  command   | start, busy, i_cmd          | beat taken when start & !busy
//  result    | o_res_valid, o_res          | one-cycle strobe, no back-pressure
//  config    | i_cfg_we, i_cfg_wdata       | written when i_cfg_we, timeout
//
//  Send, ack and ticks with nothing outstanding stay in idle; send and ack give a result the cycle after.
//  Other ticks: accept, then ST_CHECK compares the age of the oldest stamp with the
//  timeout; on expiry ST_RESEND resends each outstanding packet (up to WINDOW), one per cycle.
//  busy is high while a tick checks the stamp or walks the window.
//  Synchronous reset clears base, last sequence and time and sets the timeout to 100.
//  The result side cannot stall.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gbn_pkg::t_cmd                 i_cmd,
    output logic                          o_res_valid,
    output gbn_pkg::t_res                 o_res,
    input  logic                          i_cfg_we,
    input  logic [gbn_pkg::TO_BITS-1:0]   i_cfg_wdata
);

    localparam int SB = gbn_pkg::SEQ_BITS;
    localparam int TB = gbn_pkg::TIME_BITS;
    localparam int LB = gbn_pkg::SLOT_BITS;
    localparam int CB = gbn_pkg::CNT_BITS;

    gbn_pkg::t_state           r_state, n_state;
    logic [SB-1:0]             r_base, n_base;
    logic [SB-1:0]             r_last_seq, n_last_seq;
    logic [TB-1:0]             r_time, n_time;
    logic [gbn_pkg::TO_BITS-1:0] r_timeout;
    logic [SB-1:0]             r_first, n_first;
    logic [CB-1:0]             r_left, n_left;
    logic                      r_res_valid, n_res_valid;
    gbn_pkg::t_res             r_res, n_res;

    logic [TB-1:0]             mem [gbn_pkg::WINDOW];
    logic [TB-1:0]             r_rd_data;
    logic                      mem_we;
    logic [LB-1:0]             mem_waddr;
    logic [TB-1:0]             mem_wdata;
    logic                      mem_re;
    logic [LB-1:0]             mem_raddr;

    logic                      accept;
    logic [SB-1:0]             inflight;
    logic [SB-1:0]             next_seq;
    logic [SB-1:0]             ack_d;
    logic [TB-1:0]             age;

    assign busy      = (r_state != gbn_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign inflight  = r_last_seq - r_base;
    assign next_seq  = r_last_seq + SB'(1);
    assign ack_d     = SB'(i_cmd.ack_seq) - r_base;
    assign age       = r_time - r_rd_data;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_last_seq  = r_last_seq;
        n_time      = r_time;
        n_first     = r_first;
        n_left      = r_left;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = next_seq[LB-1:0];
        mem_wdata   = r_time;
        mem_re      = 1'b0;
        mem_raddr   = r_base[LB-1:0] + LB'(1);
        case (r_state)
            gbn_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        gbn_pkg::ACT_SEND: begin
                            n_res_valid     = 1'b1;
                            n_res.base_seq  = 32'(r_base);
                            n_res.last      = 1'b1;
                            if (inflight < SB'(gbn_pkg::WINDOW)) begin
                                n_last_seq   = next_seq;
                                mem_we       = 1'b1;
                                n_res.kind   = gbn_pkg::KIND_TX;
                                n_res.seq_no = 32'(next_seq);
                                n_res.slot   = next_seq[LB-1:0];
                            end else begin
                                n_res.kind   = gbn_pkg::KIND_FULL;
                                n_res.seq_no = '0;
                                n_res.slot   = '0;
                            end
                        end
                        gbn_pkg::ACT_ACK: begin
                            if (i_cmd.ack_valid && i_cmd.ack_flags[0] &&
                                ack_d != '0 && !ack_d[SB-1]) begin
                                if (ack_d > inflight) begin
                                    n_base = r_last_seq;
                                end else begin
                                    n_base = SB'(i_cmd.ack_seq);
                                end
                            end
                            n_res_valid    = 1'b1;
                            n_res.kind     = gbn_pkg::KIND_ACK;
                            n_res.seq_no   = '0;
                            n_res.slot     = '0;
                            n_res.base_seq = 32'(n_base);
                            n_res.last     = 1'b1;
                        end
                        gbn_pkg::ACT_TICK: begin
                            n_time = r_time + TB'(1);
                            if (inflight != '0) begin
                                mem_re  = 1'b1;
                                n_first = r_base + SB'(1);
                                n_left  = inflight[CB-1:0];
                                n_state = gbn_pkg::ST_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gbn_pkg::ST_CHECK: begin
                if (32'(age) >= 32'(r_timeout)) begin
                    n_state = gbn_pkg::ST_RESEND;
                end else begin
                    n_state = gbn_pkg::ST_IDLE;
                end
            end
            gbn_pkg::ST_RESEND: begin
                mem_we         = 1'b1;
                mem_waddr      = r_first[LB-1:0];
                n_res_valid    = 1'b1;
                n_res.kind     = gbn_pkg::KIND_RETX;
                n_res.seq_no   = 32'(r_first);
                n_res.slot     = r_first[LB-1:0];
                n_res.base_seq = 32'(r_base);
                n_res.last     = (r_left == CB'(1));
                n_first        = r_first + SB'(1);
                n_left         = r_left - CB'(1);
                if (r_left == CB'(1)) begin
                    n_state = gbn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbn_pkg::ST_IDLE;
            r_base      <= '0;
            r_last_seq  <= '0;
            r_time      <= '0;
            r_timeout   <= gbn_pkg::TO_BITS'(100);
            r_left      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_last_seq  <= n_last_seq;
            r_time      <= n_time;
            r_left      <= n_left;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_res   <= n_res;
    end

    // stamp RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CB'(gbn_pkg::WINDOW))
        else $error("resend count beyond window");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inflight <= SB'(gbn_pkg::WINDOW))
        else $error("outstanding count beyond window");

    a_send_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.action == gbn_pkg::ACT_SEND) |=>
            o_res_valid && o_res.last &&
            (o_res.kind == gbn_pkg::KIND_TX || o_res.kind == gbn_pkg::KIND_FULL))
        else $error("send request without result");

    a_retx_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.kind == gbn_pkg::KIND_RETX) |->
            $past(r_state == gbn_pkg::ST_RESEND))
        else $error("retransmit beat outside resend walk");

    a_retx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.kind == gbn_pkg::KIND_RETX) && !o_res.last |->
            r_state == gbn_pkg::ST_RESEND)
        else $error("resend walk ended before last beat");
`endif

endmodule
